/* design/ir2d_pkg.sv */
package ir2d_pkg;

    localparam int unsigned SENSOR_COUNT = 6;
    localparam int unsigned TABLE_SIZE   = 6;
    localparam int unsigned ADC_BITS     = 12;
    localparam int unsigned ID_W         = 3;
    localparam int unsigned DIST_W       = 8;

    localparam int unsigned DIFF_W = ((ADC_BITS > 12) ? ADC_BITS : 12) + 1;
    localparam int unsigned SQ_W   = 2 * DIFF_W;
    localparam int unsigned N_W    = 31;
    localparam int unsigned Q_BITS = 12;
    localparam int unsigned CMP_W  = SQ_W + Q_BITS;
    localparam int unsigned C_W    = 11;
    localparam int unsigned D_W    = 9;
    localparam int unsigned THR_W  = 11;
    localparam int unsigned TOT_W  = Q_BITS + 2;
    localparam int unsigned MAG_W  = TOT_W - 1;
    localparam int unsigned PROD_W = 2 * MAG_W;
    localparam int unsigned MM_W   = 9;

    localparam int unsigned RECIP_10    = 6554;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned MAX_RESET   = 200;

    typedef struct packed {
        logic [ID_W-1:0]     sensor_id;
        logic [ADC_BITS-1:0] ambient_sample;
        logic [ADC_BITS-1:0] led1_sample;
        logic [ADC_BITS-1:0] led2_sample;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]     sensor_number;
        logic [ADC_BITS-1:0] reflected_level;
        logic [DIST_W-1:0]   distance_mm;
    } t_result;

    typedef struct packed {
        logic [N_W-1:0]        num;
        logic signed [C_W-1:0] c;
        logic signed [D_W-1:0] d10;
    } t_coef;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [ADC_BITS-1:0]   level;
        logic signed [D_W-1:0] d10;
        logic                  known;
    } t_side;

    typedef struct packed {
        logic [N_W-1:0]    rem;
        logic [SQ_W-1:0]   sq;
        logic [Q_BITS-1:0] quo;
        logic              sat;
    } t_div;

    function automatic t_coef make_coef(input int a, input int c, input int d);
        t_coef co;
        co.num = N_W'(10 * a * a);
        co.c   = C_W'(c);
        co.d10 = D_W'(d);
        return co;
    endfunction

    function automatic t_coef coef_lookup(input logic [ID_W-1:0] id, input logic near);
        t_coef co;
        case (id)
            3'd0:    co = near ? make_coef(12300, -835, -127) : make_coef(2910, 240, 165);
            3'd1:    co = make_coef(2168, 188, 0);
            3'd2:    co = make_coef(2650, 807, -89);
            3'd3:    co = make_coef(1710, 776, -71);
            3'd4:    co = make_coef(2927, 230, 0);
            3'd5:    co = near ? make_coef(10000, -500, -87) : make_coef(3560, 170, 150);
            default: co = make_coef(0, 0, 0);
        endcase
        return co;
    endfunction

    function automatic logic [THR_W-1:0] threshold_of(input logic [ID_W-1:0] id);
        logic [THR_W-1:0] thr;
        case (id)
            3'd0:    thr = THR_W'(900);
            3'd5:    thr = THR_W'(1140);
            default: thr = '0;
        endcase
        return thr;
    endfunction

endpackage

/* design/ir2d_front.sv */
module ir2d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ir2d_pkg::t_item i_item,
    output logic            o_valid,
    output ir2d_pkg::t_side o_side,
    output ir2d_pkg::t_div  o_div
);

    logic [ir2d_pkg::ADC_BITS-1:0] n_lit;
    logic [ir2d_pkg::ADC_BITS-1:0] n_level;

    logic                          r_a_valid;
    logic [ir2d_pkg::ID_W-1:0]     r_a_id;
    logic [ir2d_pkg::ADC_BITS-1:0] r_a_level;

    logic                                   n_near;
    ir2d_pkg::t_coef                        n_coef;
    logic signed [ir2d_pkg::DIFF_W:0]       n_diff_s;
    logic [ir2d_pkg::DIFF_W:0]              n_diff_abs;
    ir2d_pkg::t_side                        n_b_side;

    logic                        r_b_valid;
    logic [ir2d_pkg::DIFF_W-1:0] r_b_diff;
    logic [ir2d_pkg::N_W-1:0]    r_b_num;
    ir2d_pkg::t_side             r_b_side;

    logic                      r_c_valid;
    logic [ir2d_pkg::SQ_W-1:0] r_c_sq;
    logic [ir2d_pkg::N_W-1:0]  r_c_num;
    ir2d_pkg::t_side           r_c_side;

    logic                      n_sat;

    logic            r_d_valid;
    ir2d_pkg::t_div  r_d_div;
    ir2d_pkg::t_side r_d_side;

    always_comb begin
        n_lit   = i_item.sensor_id[0] ? i_item.led1_sample : i_item.led2_sample;
        n_level = (n_lit > i_item.ambient_sample) ? (n_lit - i_item.ambient_sample) : '0;
    end

    always_comb begin
        n_near     = ir2d_pkg::DIFF_W'(r_a_level)
                     >= ir2d_pkg::DIFF_W'(ir2d_pkg::threshold_of(r_a_id));
        n_coef     = ir2d_pkg::coef_lookup(r_a_id, n_near);
        n_diff_s   = $signed({1'b0, ir2d_pkg::DIFF_W'(r_a_level)})
                     - (ir2d_pkg::DIFF_W + 1)'(n_coef.c);
        n_diff_abs = n_diff_s[ir2d_pkg::DIFF_W] ? -n_diff_s : n_diff_s;
        n_b_side.id    = r_a_id;
        n_b_side.level = r_a_level;
        n_b_side.d10   = n_coef.d10;
        n_b_side.known = (32'(r_a_id) < ir2d_pkg::SENSOR_COUNT)
                         && (32'(r_a_id) < ir2d_pkg::TABLE_SIZE);
    end

    assign n_sat = ir2d_pkg::CMP_W'(r_c_num) >= {r_c_sq, {ir2d_pkg::Q_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_id      <= i_item.sensor_id;
        r_a_level   <= n_level;
        r_b_diff    <= n_diff_abs[ir2d_pkg::DIFF_W-1:0];
        r_b_num     <= n_coef.num;
        r_b_side    <= n_b_side;
        r_c_sq      <= ir2d_pkg::SQ_W'(r_b_diff) * ir2d_pkg::SQ_W'(r_b_diff);
        r_c_num     <= r_b_num;
        r_c_side    <= r_b_side;
        r_d_div.rem <= r_c_num;
        r_d_div.sq  <= r_c_sq;
        r_d_div.quo <= '0;
        r_d_div.sat <= n_sat;
        r_d_side    <= r_c_side;
    end

    assign o_valid = r_d_valid;
    assign o_side  = r_d_side;
    assign o_div   = r_d_div;

endmodule

/* design/ir2d_div_cell.sv */
module ir2d_div_cell #(
    parameter int unsigned K = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ir2d_pkg::t_side i_side,
    input  ir2d_pkg::t_div  i_div,
    output logic            o_valid,
    output ir2d_pkg::t_side o_side,
    output ir2d_pkg::t_div  o_div
);

    logic [ir2d_pkg::CMP_W-1:0] n_shifted;
    logic [ir2d_pkg::CMP_W-1:0] n_rem_wide;
    logic                       n_ge;
    ir2d_pkg::t_div             n_div;

    logic            r_valid;
    ir2d_pkg::t_side r_side;
    ir2d_pkg::t_div  r_div;

    always_comb begin
        n_shifted  = ir2d_pkg::CMP_W'(i_div.sq) << K;
        n_rem_wide = ir2d_pkg::CMP_W'(i_div.rem);
        n_ge       = n_rem_wide >= n_shifted;
        n_div      = i_div;
        if (n_ge) begin
            n_div.rem    = ir2d_pkg::N_W'(n_rem_wide - n_shifted);
            n_div.quo[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_div  <= n_div;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

/* design/ir2d_back.sv */
module ir2d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  ir2d_pkg::t_side             i_side,
    input  ir2d_pkg::t_div              i_div,
    input  logic [ir2d_pkg::DIST_W-1:0] i_max_distance,
    output logic                        o_valid,
    output ir2d_pkg::t_result           o_result
);

    logic [ir2d_pkg::Q_BITS-1:0]       n_quo;
    logic signed [ir2d_pkg::TOT_W-1:0] n_total;
    logic [ir2d_pkg::PROD_W-1:0]       n_prod;
    logic [ir2d_pkg::MM_W-1:0]         n_mm;

    logic                          r_e_valid;
    logic [ir2d_pkg::ID_W-1:0]     r_e_id;
    logic [ir2d_pkg::ADC_BITS-1:0] r_e_level;
    logic [ir2d_pkg::MM_W-1:0]     r_e_mm;

    logic [ir2d_pkg::DIST_W-1:0] n_dist;

    logic              r_valid;
    ir2d_pkg::t_result r_result;

    always_comb begin
        n_quo   = i_div.sat ? '1 : i_div.quo;
        n_total = $signed({2'b00, n_quo}) + ir2d_pkg::TOT_W'(i_side.d10);
        n_prod  = ir2d_pkg::PROD_W'(n_total[ir2d_pkg::MAG_W-1:0])
                  * ir2d_pkg::PROD_W'(ir2d_pkg::RECIP_10);
        if (!i_side.known || n_total[ir2d_pkg::TOT_W-1]) begin
            n_mm = '0;
        end else begin
            n_mm = n_prod[ir2d_pkg::RECIP_SHIFT +: ir2d_pkg::MM_W];
        end
    end

    assign n_dist = (r_e_mm > ir2d_pkg::MM_W'(i_max_distance))
                    ? i_max_distance : r_e_mm[ir2d_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_e_valid <= i_valid;
            r_valid   <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_id                   <= i_side.id;
        r_e_level                <= i_side.level;
        r_e_mm                   <= n_mm;
        r_result.sensor_number   <= r_e_id;
        r_result.reflected_level <= r_e_level;
        r_result.distance_mm     <= n_dist;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/ir_reflectance_to_distance.sv */
// Converts one infrared sensor reading per item into a reflected level and a distance in
// millimeters. A new item may be started in every clock cycle and busy stays low, so the
// block never holds off a source. Each result is marked by o_valid for a single cycle; the
// receiver cannot stall the block and must take every result when it is shown. The path
// runs through four front stages (level, coefficient select, squaring, range check), a row
// of twelve divider cells that each settle one quotient bit, and two final stages for
// scaling and clamping. The maximum distance register should only be written while no
// item is in flight.
module ir_reflectance_to_distance (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ir2d_pkg::t_item             i_item,
    output logic                        o_valid,
    output ir2d_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ir2d_pkg::DIST_W-1:0] i_cfg_data
);

    localparam int unsigned NCELL = ir2d_pkg::Q_BITS;

    logic [ir2d_pkg::DIST_W-1:0] r_max_distance;

    logic            w_valid [NCELL+1];
    ir2d_pkg::t_side w_side  [NCELL+1];
    ir2d_pkg::t_div  w_div   [NCELL+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= ir2d_pkg::DIST_W'(ir2d_pkg::MAX_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_distance <= i_cfg_data;
        end
    end

    ir2d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (w_valid[0]),
        .o_side  (w_side[0]),
        .o_div   (w_div[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ir2d_div_cell #(
            .K (NCELL - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_side  (w_side[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_side  (w_side[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    ir2d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid[NCELL]),
        .i_side         (w_side[NCELL]),
        .i_div          (w_div[NCELL]),
        .i_max_distance (r_max_distance),
        .o_valid        (o_valid),
        .o_result       (o_result)
    );

endmodule

/* verif/ir2d_distance_checker.sv */
`timescale 1ns / 1ps

module ir2d_distance_checker
    import ir2d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_item             i_item,
    input  logic              i_valid,
    input  t_result           i_result,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [DIST_W-1:0] i_cfg_data,
    output int                o_mismatches,
    output int                o_in_flight
);

    localparam longint QUOTIENT_CEIL = 64'h0000_0000_FFFF_FFFF;

    t_result           awaited_readings[$];
    logic [DIST_W-1:0] clamp_mm = DIST_W'(MAX_RESET);
    int                mismatches = 0;

    function automatic t_result convert_reading(input t_item it, input logic [DIST_W-1:0] cap);
        t_result r;
        logic [ID_W-1:0] id;
        longint ambient, lit, level, thr, a, c, d10, diff, sq, quo, total, mm;
        id      = it.sensor_id;
        ambient = it.ambient_sample;
        lit     = id[0] ? it.led1_sample : it.led2_sample;
        level   = (lit > ambient) ? lit - ambient : 0;
        r.sensor_number   = id;
        r.reflected_level = ADC_BITS'(level);
        r.distance_mm     = '0;
        if (id < SENSOR_COUNT) begin
            thr = (id == 0) ? 900 : (id == 5) ? 1140 : 0;
            case (id)
                0:       begin a = 2910; c = 240; d10 = 165; end
                1:       begin a = 2168; c = 188; d10 = 0; end
                2:       begin a = 2650; c = 807; d10 = -89; end
                3:       begin a = 1710; c = 776; d10 = -71; end
                4:       begin a = 2927; c = 230; d10 = 0; end
                default: begin a = 3560; c = 170; d10 = 150; end
            endcase
            if (level >= thr && id == 0) begin
                a = 12300; c = -835; d10 = -127;
            end else if (level >= thr && id == 5) begin
                a = 10000; c = -500; d10 = -87;
            end
            diff = level - c;
            if (diff < 0) diff = -diff;
            sq  = diff * diff;
            quo = (sq == 0) ? QUOTIENT_CEIL : (10 * a * a) / sq;
            if (quo > QUOTIENT_CEIL) quo = QUOTIENT_CEIL;
            total = quo + d10;
            mm    = (total < 0) ? 0 : total / 10;
            if (mm > cap) mm = cap;
            r.distance_mm = DIST_W'(mm);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            awaited_readings.delete();
            clamp_mm = DIST_W'(MAX_RESET);
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                clamp_mm = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                awaited_readings.push_back(convert_reading(i_item, clamp_mm));
            end
            if (i_valid) begin
                if (awaited_readings.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_result);
                    mismatches++;
                end else begin
                    want = awaited_readings.pop_front();
                    if (i_result.sensor_number !== want.sensor_number) begin
                        $display("%0t: sensor_number expected %0d actual %0d", $time,
                                 want.sensor_number, i_result.sensor_number);
                        mismatches++;
                    end
                    if (i_result.reflected_level !== want.reflected_level) begin
                        $display("%0t: reflected_level expected %0d actual %0d", $time,
                                 want.reflected_level, i_result.reflected_level);
                        mismatches++;
                    end
                    if (i_result.distance_mm !== want.distance_mm) begin
                        $display("%0t: distance_mm expected %0d actual %0d (sensor %0d)",
                                 $time, want.distance_mm, i_result.distance_mm,
                                 want.sensor_number);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_in_flight  <= awaited_readings.size();
    end

endmodule

/* verif/tb_ir_reflectance_to_distance.sv */
`timescale 1ns / 1ps

module tb_ir_reflectance_to_distance;
    import ir2d_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 75;
    localparam int PHASE_COUNT   = 6;
    localparam int MAX_ADC       = (1 << ADC_BITS) - 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              o_valid;
    t_result           o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DIST_W-1:0] i_cfg_data;
    int                mismatch_total;
    int                in_flight;
    int                cycle_count;

    ir_reflectance_to_distance DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    ir2d_distance_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_total),
        .o_in_flight  (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_ir_reflectance_to_distance: done, errors");
        $finish;
    end

    function automatic t_item make_reading(input int id, input int amb, input int l1,
                                           input int l2);
        t_item it;
        it.sensor_id      = ID_W'(id);
        it.ambient_sample = ADC_BITS'(amb);
        it.led1_sample    = ADC_BITS'(l1);
        it.led2_sample    = ADC_BITS'(l2);
        return it;
    endfunction

    // Most items carry a chosen reflected level on the sensor's own LED phase; the
    // rest are raw samples or have the lit sample at or below ambient.
    function automatic t_item random_reading();
        int id, amb, lit, other, level, mode;
        id    = ($urandom_range(99) < 6) ? $urandom_range(7, 6) : $urandom_range(5);
        mode  = $urandom_range(99);
        other = $urandom_range(MAX_ADC);
        if (mode < 15) begin
            amb = $urandom_range(MAX_ADC);
            lit = $urandom_range(MAX_ADC);
        end else if (mode < 30) begin
            lit = $urandom_range(MAX_ADC - 1);
            amb = $urandom_range(MAX_ADC, lit);
        end else begin
            if (mode < 75) begin
                level = $urandom_range(1500);
            end else if (mode < 80) begin
                level = $urandom_range(MAX_ADC);
            end else begin
                case ($urandom_range(9))
                    0:       level = 188;
                    1:       level = 807;
                    2:       level = 776;
                    3:       level = 230;
                    4:       level = 240;
                    5:       level = 170;
                    6:       level = 900;
                    7:       level = 1140;
                    8:       level = 0;
                    default: level = MAX_ADC;
                endcase
                level = level + $urandom_range(4) - 2;
                if (level < 0) level = 0;
                if (level > MAX_ADC) level = MAX_ADC;
            end
            amb = $urandom_range(MAX_ADC - level);
            lit = amb + level;
        end
        return (id % 2) ? make_reading(id, amb, lit, other) : make_reading(id, amb, other, lit);
    endfunction

    task automatic send_reading(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_at_random(input int percent);
        while ($urandom_range(99) < percent) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_clamp(input logic [DIST_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int idle_pct;
        logic [DIST_W-1:0] clamp;
        t_item directed[$];
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int id = 0; id < 8; id++) begin
            directed.push_back(make_reading(id, 0, MAX_ADC, MAX_ADC));
        end
        directed.push_back(make_reading(0, 0, 0, 0));
        directed.push_back(make_reading(3, MAX_ADC, 0, 0));
        directed.push_back(make_reading(6, MAX_ADC, 0, MAX_ADC));
        directed.push_back(make_reading(0, 0, 0, 240));
        directed.push_back(make_reading(1, 12, 200, 0));
        directed.push_back(make_reading(2, 0, 0, 807));
        directed.push_back(make_reading(3, 100, 876, 0));
        directed.push_back(make_reading(4, 0, 0, 230));
        directed.push_back(make_reading(5, 0, 170, 0));
        directed.push_back(make_reading(0, 0, 0, 899));
        directed.push_back(make_reading(0, 0, 0, 900));
        directed.push_back(make_reading(5, 0, 1139, 0));
        directed.push_back(make_reading(5, 0, 1140, 0));
        directed.push_back(make_reading(7, 5, 4000, 1));
        foreach (directed[k]) send_reading(directed[k]);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       clamp = '1;
                1:       clamp = '0;
                3:       clamp = DIST_W'(1);
                4:       clamp = DIST_W'(MAX_RESET);
                default: clamp = DIST_W'($urandom_range(255));
            endcase
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 66;
                default: idle_pct = 17;
            endcase
            write_clamp(clamp);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_at_random(idle_pct);
                send_reading(random_reading());
            end
        end
        write_clamp('1);
        start <= 1'b0;

        while (in_flight != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0 && in_flight == 0) begin
            $display("tb_ir_reflectance_to_distance: done, clean");
        end else begin
            $display("tb_ir_reflectance_to_distance: done, errors");
        end
        $finish;
    end

endmodule
